// ===== hw/rtl/bfsa_pkg.sv =====
// bfsa_pkg: shared types and constants for the best-fit slot allocator
// holds beat payload structs, status codes, mode codes and state encoding
// no dependencies
`timescale 1ns / 1ps

package bfsa_pkg;

    localparam int SLOT_COUNT_DEF   = 16;
    localparam int ADDRESS_BITS_DEF = 32;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        STAT_LOADED    = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_ALLOCATED = 2'd2,
        STAT_NO_FIT    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_TAIL,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] slot_start;
        logic [31:0] amount;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] granted_base;
        logic [3:0]  chosen_slot;
    } out_item_t;

endpackage

// ===== hw/rtl/best_fit_slot_allocator.sv =====
// Best-fit slot allocator. A load beat appends a free slot (base, length) at the fill
// pointer; an allocate beat scans all SLOT_COUNT table entries, one memory read per cycle,
// and picks the valid slot with the smallest leftover that still fits, lowest index on a
// tie. The chosen slot's base is granted, the base moves up and the length shrinks by the
// request; a slot that reaches zero length is dropped. A load result passes through the load
// and done states to the output register; an allocate result passes through the scan, tail,
// update and done states, as the single read port of the slot table is walked one entry per
// cycle and the chosen entry is then written back. The next beat is accepted once the block
// is back in idle, after the finished result has waited in the done state for the output
// register to free up. One item is in work at a time; a finished result waits in the output
// register while the next item is accepted.
// Valid bits clear at reset, the table memories need no clearing.
`timescale 1ns / 1ps

module best_fit_slot_allocator #(
    parameter int SLOT_COUNT   = bfsa_pkg::SLOT_COUNT_DEF,
    parameter int ADDRESS_BITS = bfsa_pkg::ADDRESS_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bfsa_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bfsa_pkg::out_item_t m_data
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int FILL_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(SLOT_COUNT);

    // slot table
    logic [ADDRESS_BITS-1:0] base_mem [SLOT_COUNT];
    logic [31:0]             len_mem  [SLOT_COUNT];

    bfsa_pkg::state_t    state_reg, state_next;
    bfsa_pkg::in_item_t  item_reg, item_next;
    bfsa_pkg::out_item_t res_reg, res_next;
    bfsa_pkg::out_item_t m_data_reg, m_data_next;
    logic                m_valid_reg, m_valid_next;

    logic [SLOT_COUNT-1:0]   valid_reg, valid_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [IDX_W-1:0]        scan_addr_reg, scan_addr_next;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic                    cmp_pending_reg;
    logic [ADDRESS_BITS-1:0] rd_base_reg;
    logic [31:0]             rd_len_reg;

    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [31:0]             best_left_reg, best_left_next;
    logic [ADDRESS_BITS-1:0] best_base_reg, best_base_next;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [ADDRESS_BITS-1:0] wr_base;
    logic [31:0]             wr_len;

    logic                    fits;
    logic [31:0]             left;
    logic                    take;

    assign s_ready = (state_reg == bfsa_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // best-fit compare on the entry read last cycle
    assign fits = cmp_pending_reg && valid_reg[cmp_idx_reg] && (rd_len_reg >= item_reg.amount);
    assign left = rd_len_reg - item_reg.amount;
    assign take = fits && (!found_reg || (left < best_left_reg));

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg;
        valid_next     = valid_reg;
        fill_next      = fill_reg;
        scan_addr_next = scan_addr_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_left_next = best_left_reg;
        best_base_next = best_base_reg;
        wr_en          = 1'b0;
        wr_addr        = best_idx_reg;
        wr_base        = best_base_reg + ADDRESS_BITS'(item_reg.amount);
        wr_len         = best_left_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (take) begin
            found_next     = 1'b1;
            best_idx_next  = cmp_idx_reg;
            best_left_next = left;
            best_base_next = rd_base_reg;
        end

        unique case (state_reg)
            bfsa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    item_next      = s_data;
                    scan_addr_next = '0;
                    found_next     = 1'b0;
                    state_next     = (s_data.mode == bfsa_pkg::MODE_ALLOC) ?
                                     bfsa_pkg::ST_SCAN : bfsa_pkg::ST_LOAD;
                end
            end
            bfsa_pkg::ST_LOAD: begin
                if (fill_reg == FULL_FILL) begin
                    res_next.status       = bfsa_pkg::STAT_FULL;
                    res_next.granted_base = '0;
                    res_next.chosen_slot  = '0;
                end else begin
                    wr_en                 = 1'b1;
                    wr_addr               = fill_reg[IDX_W-1:0];
                    wr_base               = ADDRESS_BITS'(item_reg.slot_start);
                    wr_len                = item_reg.amount;
                    valid_next[fill_reg[IDX_W-1:0]] = 1'b1;
                    fill_next             = fill_reg + 1'b1;
                    res_next.status       = bfsa_pkg::STAT_LOADED;
                    res_next.granted_base = '0;
                    res_next.chosen_slot  = 4'(fill_reg);
                end
                state_next = bfsa_pkg::ST_DONE;
            end
            bfsa_pkg::ST_SCAN: begin
                scan_addr_next = scan_addr_reg + 1'b1;
                if (scan_addr_reg == LAST_IDX) begin
                    scan_addr_next = '0;
                    state_next     = bfsa_pkg::ST_TAIL;
                end
            end
            bfsa_pkg::ST_TAIL: begin
                state_next = bfsa_pkg::ST_UPDATE;
            end
            bfsa_pkg::ST_UPDATE: begin
                if (found_reg) begin
                    wr_en                 = 1'b1;
                    if (best_left_reg == '0) begin
                        valid_next[best_idx_reg] = 1'b0;
                    end
                    res_next.status       = bfsa_pkg::STAT_ALLOCATED;
                    res_next.granted_base = 32'(best_base_reg);
                    res_next.chosen_slot  = 4'(best_idx_reg);
                end else begin
                    res_next.status       = bfsa_pkg::STAT_NO_FIT;
                    res_next.granted_base = '0;
                    res_next.chosen_slot  = '0;
                end
                state_next = bfsa_pkg::ST_DONE;
            end
            bfsa_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = bfsa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bfsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= bfsa_pkg::ST_IDLE;
            m_valid_reg     <= 1'b0;
            valid_reg       <= '0;
            fill_reg        <= '0;
            scan_addr_reg   <= '0;
            cmp_pending_reg <= 1'b0;
            found_reg       <= 1'b0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            valid_reg       <= valid_next;
            fill_reg        <= fill_next;
            scan_addr_reg   <= scan_addr_next;
            cmp_pending_reg <= (state_reg == bfsa_pkg::ST_SCAN);
            found_reg       <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
        best_idx_reg  <= best_idx_next;
        best_left_reg <= best_left_next;
        best_base_reg <= best_base_next;
        cmp_idx_reg   <= scan_addr_reg;
    end

    // slot table, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            base_mem[wr_addr] <= wr_base;
            len_mem[wr_addr]  <= wr_len;
        end
        rd_base_reg <= base_mem[scan_addr_reg];
        rd_len_reg  <= len_mem[scan_addr_reg];
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_FILL)
        else $error("fill pointer past table size");

    a_valid_below_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg >> fill_reg) == '0)
        else $error("valid entry above fill pointer");

    a_load_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bfsa_pkg::ST_LOAD && fill_reg != FULL_FILL)
        |=> (fill_reg == $past(fill_reg) + 1'b1) && res_reg.status == bfsa_pkg::STAT_LOADED)
        else $error("load did not advance fill pointer");

    a_nofit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == bfsa_pkg::STAT_NO_FIT)
        |-> (m_data.granted_base == '0 && m_data.chosen_slot == '0))
        else $error("no-fit beat carries nonzero base or slot");

endmodule

// ===== dv/best_fit_slot_allocator_tb.sv =====
// best_fit_slot_allocator_tb: self-checking bench for the best-fit slot allocator
// drives load and allocate beats, predicts each result and compares it field by field
// depends on bfsa_pkg and best_fit_slot_allocator from hw/rtl
`timescale 1ns / 1ps

module best_fit_slot_allocator_tb;

    localparam int SLOTS        = bfsa_pkg::SLOT_COUNT_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    bfsa_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b1;
    bfsa_pkg::out_item_t m_data;

    // shadow copy of the slot table
    logic [31:0] tab_base [SLOTS];
    logic [31:0] tab_len  [SLOTS];
    bit          tab_live [SLOTS] = '{default: 1'b0};
    int          fill_cnt = 0;

    bfsa_pkg::out_item_t expected_grants [$];
    bfsa_pkg::out_item_t want_beat;
    int                  mismatch_count = 0;
    int                  beat_idx       = 0;
    int                  cycle_count    = 0;
    int                  stall_left     = 0;
    bit                  bursts_on      = 1'b1;

    best_fit_slot_allocator uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (stall_left == 0 && bursts_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
        m_ready = (stall_left == 0);
        if (stall_left > 0)
            stall_left--;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // best fit over the shadow table, updating it the way the block should
    function automatic bfsa_pkg::out_item_t predict_grant(input bfsa_pkg::in_item_t item);
        bfsa_pkg::out_item_t r;
        bit                  found;
        int                  pick;
        logic [31:0]         best_left;
        logic [31:0]         left;
        r.status       = bfsa_pkg::STAT_NO_FIT;
        r.granted_base = '0;
        r.chosen_slot  = '0;
        if (item.mode == bfsa_pkg::MODE_LOAD) begin
            if (fill_cnt >= SLOTS) begin
                r.status = bfsa_pkg::STAT_FULL;
            end else begin
                tab_base[fill_cnt] = item.slot_start;
                tab_len[fill_cnt]  = item.amount;
                tab_live[fill_cnt] = 1'b1;
                r.status           = bfsa_pkg::STAT_LOADED;
                r.chosen_slot      = fill_cnt[3:0];
                fill_cnt++;
            end
        end else begin
            found     = 1'b0;
            pick      = 0;
            best_left = '0;
            for (int i = 0; i < SLOTS; i++) begin
                if (tab_live[i] && tab_len[i] >= item.amount) begin
                    left = tab_len[i] - item.amount;
                    if (!found || left < best_left) begin
                        found     = 1'b1;
                        pick      = i;
                        best_left = left;
                    end
                end
            end
            if (found) begin
                r.status       = bfsa_pkg::STAT_ALLOCATED;
                r.granted_base = tab_base[pick];
                r.chosen_slot  = pick[3:0];
                tab_base[pick] = tab_base[pick] + item.amount;
                tab_len[pick]  = best_left;
                if (best_left == 0)
                    tab_live[pick] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic bfsa_pkg::in_item_t load_item(input logic [31:0] base,
                                                     input logic [31:0] len);
        bfsa_pkg::in_item_t it;
        it.mode       = bfsa_pkg::MODE_LOAD;
        it.slot_start = base;
        it.amount     = len;
        return it;
    endfunction

    function automatic bfsa_pkg::in_item_t alloc_item(input logic [31:0] req);
        bfsa_pkg::in_item_t it;
        it.mode       = bfsa_pkg::MODE_ALLOC;
        it.slot_start = $urandom;
        it.amount     = req;
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_item(input bfsa_pkg::in_item_t item);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_data  = item;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_grants.push_back(predict_grant(item));
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_grants.size() == 0) begin
                report_mismatch($sformatf("beat %0d arrived with nothing pending", beat_idx));
            end else begin
                want_beat = expected_grants.pop_front();
                if (m_data.status !== want_beat.status)
                    report_mismatch($sformatf("beat %0d status got %0d want %0d",
                        beat_idx, m_data.status, want_beat.status));
                if (m_data.granted_base !== want_beat.granted_base)
                    report_mismatch($sformatf("beat %0d granted_base got %h want %h",
                        beat_idx, m_data.granted_base, want_beat.granted_base));
                if (m_data.chosen_slot !== want_beat.chosen_slot)
                    report_mismatch($sformatf("beat %0d chosen_slot got %0d want %0d",
                        beat_idx, m_data.chosen_slot, want_beat.chosen_slot));
            end
            beat_idx++;
        end
    end

    task automatic test_empty_table();
        send_item(alloc_item(32'd0));
    endtask

    task automatic test_load_edges();
        send_item(load_item(32'h0000_0000, 32'd0));          // zero-length slot
        send_item(load_item(32'hFFFF_FFF0, 32'h0000_0040));  // near the top of memory
        send_item(load_item(32'h5A5A_5A5A, 32'hFFFF_FFFF));  // longest possible slot
        send_item(load_item(32'hA5A5_A5A5, 32'd100));
        send_item(load_item(32'h0000_1000, 32'd100));
    endtask

    task automatic test_zero_request();
        // first takes the empty slot and drops it, second leaves the base in place
        send_item(alloc_item(32'd0));
        send_item(alloc_item(32'd0));
    endtask

    task automatic test_address_wrap();
        send_item(alloc_item(32'h20));
        send_item(alloc_item(32'h20));
    endtask

    task automatic test_tie_break();
        send_item(alloc_item(32'd100));
        send_item(alloc_item(32'd60));
    endtask

    task automatic test_largest_leftover();
        send_item(alloc_item(32'd40));
        // only the longest slot is left, leftover is all ones
        send_item(alloc_item(32'd0));
        send_item(alloc_item(32'hFFFF_FFFF));
        send_item(alloc_item(32'd1));
    endtask

    task automatic test_table_full();
        logic [31:0] len;
        while (fill_cnt < SLOTS) begin
            if (fill_cnt % 3 == 0)
                len = $urandom_range(1, 4096);
            else
                len = $urandom | 32'h8000_0000;
            send_item(load_item($urandom, len));
        end
        send_item(load_item($urandom, $urandom));
    endtask

    task automatic test_random_traffic(input int count, input bit with_bursts);
        int          live_idx [$];
        int          roll;
        int          trim;
        int          pick;
        logic [31:0] req;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0)
                bursts_on = with_bursts && ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                send_item(load_item($urandom, $urandom));
            end else if (roll < 20) begin
                send_item(alloc_item(32'd0));
            end else if (roll < 45) begin
                send_item(alloc_item($urandom_range(0, 255)));
            end else if (roll < 70) begin
                live_idx.delete();
                for (int i = 0; i < SLOTS; i++)
                    if (tab_live[i])
                        live_idx.push_back(i);
                if (live_idx.size() == 0) begin
                    req = $urandom;
                end else begin
                    pick = live_idx[$urandom_range(0, live_idx.size() - 1)];
                    // exact fits only while enough slots remain
                    trim = (live_idx.size() > 4) ? $urandom_range(0, 3) : $urandom_range(1, 3);
                    req  = (tab_len[pick] > trim) ? tab_len[pick] - trim : 32'd0;
                end
                send_item(alloc_item(req));
            end else begin
                send_item(alloc_item($urandom));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_table();
        test_load_edges();
        test_zero_request();
        test_address_wrap();
        test_tie_break();
        test_largest_leftover();
        test_table_full();
        test_random_traffic(900, 1'b1);
        test_random_traffic(300, 1'b0);

        bursts_on = 1'b0;
        s_valid   = 1'b0;
        while (expected_grants.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
